@@ design/lcdp_pkg.sv @@
// shared types and constants for the lcd command stream parser
package lcdp_pkg;

  // display action codes carried on the result channel
  typedef enum logic [1:0] {
    ACT_CHAR   = 2'd0,
    ACT_CMD    = 2'd1,
    ACT_LOCATE = 2'd2,
    ACT_INIT   = 2'd3
  } action_t;

  // configuration register indexes
  localparam logic [1:0] REG_PREFIX  = 2'd0;
  localparam logic [1:0] REG_SUFFIX  = 2'd1;
  localparam logic [1:0] REG_FLOOR   = 2'd2;
  localparam logic [1:0] REG_CEILING = 2'd3;

  // register reset values
  localparam logic [7:0] PREFIX_RST  = 8'hFE;
  localparam logic [7:0] SUFFIX_RST  = 8'hFD;
  localparam logic [7:0] FLOOR_RST   = 8'h20;
  localparam logic [7:0] CEILING_RST = 8'hFD;

  // frame command codes with their own meaning
  localparam logic [7:0] CODE_LOCATE = 8'h81;
  localparam logic [7:0] CODE_INIT   = 8'h82;

  // configuration values seen by the parser
  typedef struct packed {
    logic [7:0] prefix_byte;
    logic [7:0] suffix_byte;
    logic [7:0] printable_floor;
    logic [7:0] printable_ceiling;
  } cfg_t;

  // one result transaction
  typedef struct packed {
    logic       valid;
    action_t    action;
    logic [7:0] char_or_code;
    logic [7:0] row;
    logic [7:0] column;
  } result_t;

endpackage

@@ design/lcdp_parser.sv @@
// frame state and byte decode for the lcd command stream parser
module lcdp_parser #(
  parameter int FRAME_BYTES = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lcdp_pkg::cfg_t   cfg,
  input  logic             acc,
  input  logic [7:0]       rx_byte,
  output lcdp_pkg::result_t res
);
  import lcdp_pkg::*;

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int IW = $clog2(FRAME_BYTES);

  logic          in_command_r, in_command_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    frame_r [FRAME_BYTES];
  logic          store;
  logic [7:0]    code, prm_row, prm_col;

  // stored bytes beyond the count read as zero
  assign code    = (count_r > CW'(0)) ? frame_r[0] : 8'h00;
  assign prm_row = (count_r > CW'(1)) ? frame_r[1] : 8'h00;
  assign prm_col = (count_r > CW'(2)) ? frame_r[2] : 8'h00;

  // decode of one byte against the current frame state
  always_comb begin
    in_command_nxt   = in_command_r;
    count_nxt        = count_r;
    store            = 1'b0;
    res.valid        = 1'b0;
    res.action       = ACT_CHAR;
    res.char_or_code = rx_byte;
    res.row          = 8'h00;
    res.column       = 8'h00;
    if (!in_command_r) begin
      if (rx_byte == cfg.prefix_byte) begin
        in_command_nxt = 1'b1;
      end else if (rx_byte > cfg.printable_floor && rx_byte < cfg.printable_ceiling) begin
        res.valid = 1'b1;
      end
    end else if (rx_byte == cfg.suffix_byte) begin
      // execute the frame and leave command mode
      res.valid        = 1'b1;
      res.char_or_code = code;
      if (code == CODE_LOCATE) begin
        res.action = ACT_LOCATE;
        res.row    = prm_row;
        res.column = prm_col;
      end else if (code == CODE_INIT) begin
        res.action = ACT_INIT;
      end else begin
        res.action = ACT_CMD;
      end
      in_command_nxt = 1'b0;
      count_nxt      = '0;
    end else if (count_r == CW'(FRAME_BYTES)) begin
      // overlong frame is dropped silently
      in_command_nxt = 1'b0;
      count_nxt      = '0;
    end else begin
      store     = 1'b1;
      count_nxt = count_r + CW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_command_r <= 1'b0;
      count_r      <= '0;
    end else if (acc) begin
      in_command_r <= in_command_nxt;
      count_r      <= count_nxt;
    end
  end

  // frame byte storage
  always_ff @(posedge clk) begin
    if (acc && store) begin
      frame_r[count_r[IW-1:0]] <= rx_byte;
    end
  end

endmodule

@@ design/lcd_command_stream_parser_unit.sv @@
// top level of the lcd command stream parser with config registers and output skid
// output: a result is registered into out_r, or into the skid entry while out_r holds an untaken result
// throughput: one byte per cycle while in_stall is low; a two-entry output buffer keeps input open
//   while one result waits, in_stall rises only when both entries are full
// reset: synchronous active-low rst_n clears command mode, the frame count
//   and the output buffer, and loads the register defaults
module lcd_command_stream_parser_unit #(
  parameter int FRAME_BYTES = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output lcdp_pkg::action_t   out_action,
  output logic [7:0]          out_char_or_code,
  output logic [7:0]          out_row,
  output logic [7:0]          out_column
);
  import lcdp_pkg::*;

  cfg_t    cfg_r;
  result_t res;
  result_t out_r, skid_r;
  logic    in_acc, take, push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prefix_byte       <= PREFIX_RST;
      cfg_r.suffix_byte       <= SUFFIX_RST;
      cfg_r.printable_floor   <= FLOOR_RST;
      cfg_r.printable_ceiling <= CEILING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PREFIX:  cfg_r.prefix_byte       <= cfg_wdata;
        REG_SUFFIX:  cfg_r.suffix_byte       <= cfg_wdata;
        REG_FLOOR:   cfg_r.printable_floor   <= cfg_wdata;
        REG_CEILING: cfg_r.printable_ceiling <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lcdp_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .acc     (in_acc),
    .rx_byte (in_rx_byte),
    .res     (res)
  );

  // handshake terms
  assign in_stall = skid_r.valid;
  assign in_acc   = in_valid && !in_stall;
  assign take     = out_r.valid && !out_stall;
  assign push     = in_acc && res.valid;

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else if (skid_r.valid) begin
      if (take) begin
        out_r        <= skid_r;
        skid_r.valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_r.valid || take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (take) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_valid        = out_r.valid;
  assign out_action       = out_r.action;
  assign out_char_or_code = out_r.char_or_code;
  assign out_row          = out_r.row;
  assign out_column       = out_r.column;

  // skid entry only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.valid |-> out_r.valid)
    else $error("skid entry valid while output register empty");

  // a full skid entry drains into the output when taken
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_r.valid && take) |=> (out_r.valid && !skid_r.valid))
    else $error("skid entry not moved to output");

  // a byte that yields a result while the buffer is open must show up
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_r.valid)
    else $error("result lost after accepted byte");

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the lcd command stream parser unit
`timescale 1ns / 100ps

module tb;
  import lcdp_pkg::*;

  localparam int FRAME_N     = 3;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 190;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 8;

  // one display action as seen on the result channel
  typedef struct packed {
    action_t    action;
    logic [7:0] code;
    logic [7:0] row;
    logic [7:0] column;
  } display_op_t;

  // directed stimulus row: typed rows carry their own expectation
  typedef struct packed {
    logic [7:0]  rx;
    bit          typed;
    bit          has;
    display_op_t op;
  } stim_row_t;

  localparam display_op_t NO_OP = '0;
  localparam int DIR_ROWS = 26;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // outside command mode at reset settings: bounds of the printable window
    '{8'h00, 1'b1, 1'b0, NO_OP},
    '{8'h20, 1'b1, 1'b0, NO_OP},
    '{8'h21, 1'b1, 1'b1, '{ACT_CHAR, 8'h21, 8'h00, 8'h00}},
    '{8'hFC, 1'b1, 1'b1, '{ACT_CHAR, 8'hFC, 8'h00, 8'h00}},
    '{8'hFD, 1'b1, 1'b0, NO_OP},
    '{8'hFF, 1'b1, 1'b0, NO_OP},
    // empty frame issues controller command zero
    '{8'hFE, 1'b1, 1'b0, NO_OP},
    '{8'hFD, 1'b1, 1'b1, '{ACT_CMD, 8'h00, 8'h00, 8'h00}},
    // full locate with extreme parameters
    '{8'hFE, 1'b1, 1'b0, NO_OP},
    '{8'h81, 1'b1, 1'b0, NO_OP},
    '{8'hFF, 1'b1, 1'b0, NO_OP},
    '{8'h00, 1'b1, 1'b0, NO_OP},
    '{8'hFD, 1'b1, 1'b1, '{ACT_LOCATE, 8'h81, 8'hFF, 8'h00}},
    // init
    '{8'hFE, 1'b1, 1'b0, NO_OP},
    '{8'h82, 1'b1, 1'b0, NO_OP},
    '{8'hFD, 1'b1, 1'b1, '{ACT_INIT, 8'h82, 8'h00, 8'h00}},
    // short locate, missing column
    '{8'hFE, 1'b1, 1'b0, NO_OP},
    '{8'h81, 1'b1, 1'b0, NO_OP},
    '{8'h07, 1'b1, 1'b0, NO_OP},
    '{8'hFD, 1'b0, 1'b0, NO_OP},
    // prefix stored as data, then an overlong frame is dropped
    '{8'hFE, 1'b1, 1'b0, NO_OP},
    '{8'hFE, 1'b0, 1'b0, NO_OP},
    '{8'h44, 1'b0, 1'b0, NO_OP},
    '{8'h55, 1'b0, 1'b0, NO_OP},
    '{8'h66, 1'b0, 1'b0, NO_OP},
    '{8'h41, 1'b0, 1'b0, NO_OP}
  };

  // register settings per phase, some phases draw random values instead
  localparam cfg_t CFG_PLAN [PHASES] = '{
    '{8'hFE, 8'hFD, 8'h20, 8'hFD},
    '{8'h3C, 8'h3E, 8'h20, 8'h7F},
    '{8'h55, 8'h55, 8'h00, 8'hFF},
    '{8'h00, 8'hFF, 8'h80, 8'h81},
    '{8'hFF, 8'h00, 8'hFF, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 8'h0D, 8'h1F, 8'h7F},
    '{8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFE, 8'hFD, 8'h20, 8'hFD}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = REG_PREFIX;
  logic [7:0]          cfg_wdata = 8'h00;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  action_t             out_action;
  logic [7:0]          out_char_or_code;
  logic [7:0]          out_row;
  logic [7:0]          out_column;

  // parser state mirror
  cfg_t        cfg_now;
  bit          cmd_open;
  int          stored_n;
  logic [7:0]  frame_buf [FRAME_N];

  display_op_t pending_ops [$];
  int          errors = 0;
  int          kept = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          quiet = 0;

  lcd_command_stream_parser_unit #(
    .FRAME_BYTES(FRAME_N)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_action       (out_action),
    .out_char_or_code (out_char_or_code),
    .out_row          (out_row),
    .out_column       (out_column)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic clear_frame();
    cmd_open = 1'b0;
    stored_n = 0;
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
  endtask

  // advance the parser mirror by one byte
  task automatic parse_byte(input logic [7:0] b, output bit has, output display_op_t op,
                            output bit ignored);
    has = 1'b0;
    op = NO_OP;
    ignored = 1'b0;
    if (!cmd_open) begin
      if (b == cfg_now.prefix_byte) begin
        cmd_open = 1'b1;
      end else if (b > cfg_now.printable_floor && b < cfg_now.printable_ceiling) begin
        has = 1'b1;
        op = '{ACT_CHAR, b, 8'h00, 8'h00};
      end else begin
        ignored = 1'b1;
      end
    end else if (b == cfg_now.suffix_byte) begin
      // execute the frame, unstored bytes read as zero
      has = 1'b1;
      op.code = frame_buf[0];
      if (frame_buf[0] == CODE_LOCATE) begin
        op.action = ACT_LOCATE;
        op.row = frame_buf[1];
        op.column = frame_buf[2];
      end else if (frame_buf[0] == CODE_INIT) begin
        op.action = ACT_INIT;
      end else begin
        op.action = ACT_CMD;
      end
      clear_frame();
    end else if (stored_n >= FRAME_N) begin
      // overlong frame aborts silently
      clear_frame();
    end else begin
      frame_buf[stored_n] = b;
      stored_n++;
    end
  endtask

  // offer one byte, record the expectation once the transaction completes
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0, input bit t_has = 1'b0,
                           input display_op_t t_op = '0);
    bit          has;
    bit          ignored;
    display_op_t op;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b, has, op, ignored);
    if (typed) begin
      has = t_has;
      op = t_op;
    end
    if (has) pending_ops.push_back(op);
    if (!ignored) kept++;
  endtask

  // stop offering and let every expected result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    logic [7:0] vals [4];
    vals[REG_PREFIX]  = c.prefix_byte;
    vals[REG_SUFFIX]  = c.suffix_byte;
    vals[REG_FLOOR]   = c.printable_floor;
    vals[REG_CEILING] = c.printable_ceiling;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_now = c;
  endtask

  // well-formed frame with random content, sometimes overlong
  task automatic send_frame();
    int         n;
    logic [7:0] b;
    n = ($urandom_range(7) == 0) ? $urandom_range(5, 4) : $urandom_range(3);
    send_byte(cfg_now.prefix_byte);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        case ($urandom_range(3))
          0: b = CODE_LOCATE;
          1: b = CODE_INIT;
          default: b = 8'($urandom_range(255));
        endcase
      end else begin
        b = 8'($urandom_range(255));
      end
      send_byte(b);
    end
    send_byte(cfg_now.suffix_byte);
  endtask

  // result receiver with random stall and one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ops.size() == 0) begin
        report_mismatch($sformatf("unexpected result action %0d code %02h",
                                  out_action, out_char_or_code));
      end else begin
        display_op_t exp_op;
        exp_op = pending_ops.pop_front();
        if (out_action !== exp_op.action)
          report_mismatch($sformatf("action %0d, expected %0d", out_action, exp_op.action));
        if (out_char_or_code !== exp_op.code)
          report_mismatch($sformatf("char_or_code %02h, expected %02h",
                                    out_char_or_code, exp_op.code));
        if (out_row !== exp_op.row)
          report_mismatch($sformatf("row %02h, expected %02h", out_row, exp_op.row));
        if (out_column !== exp_op.column)
          report_mismatch($sformatf("column %02h, expected %02h", out_column, exp_op.column));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    bit   held;
    bit   paused;
    held = 1'b0;
    paused = 1'b0;
    cfg_now = '{PREFIX_RST, SUFFIX_RST, FLOOR_RST, CEILING_RST};
    clear_frame();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings
    snd_idle = 17;
    rcv_idle = 54;
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].has, DIRECTED[i].op);

    // random phases across register settings and idle patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      snd_idle = (ph < 3) ? 17 : (ph < 6) ? 54 : 0;
      rcv_idle = (ph < 3) ? 54 : (ph < 6) ? 17 : 0;
      wait_idle();
      c = CFG_PLAN[ph];
      if (ph == 5 || ph == 7)
        c = '{8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255))};
      write_config(c);
      kept = 0;
      while (kept < PHASE_ITEMS) begin
        if (ph == 0 && !held && kept >= 60) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (ph == 6 && !paused && kept >= 100) begin
          paused = 1'b1;
          wait_idle();
        end
        if ($urandom_range(99) < 70) send_frame();
        else if ($urandom_range(1) == 0) send_byte(8'($urandom_range(255)));
        else send_byte(8'($urandom_range(cfg_now.printable_ceiling, cfg_now.printable_floor)));
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
design/lcdp_pkg.sv
design/lcdp_parser.sv
design/lcd_command_stream_parser_unit.sv
tb/tb.sv
